// ===== hdl/stws_pkg.sv =====
// ============================================================================
// stws_pkg
// Shared types and constants for the sum tree weighted sampler.
// ============================================================================
`default_nettype none

package stws_pkg;

  // Default sizing handed to the top level parameters
  localparam int unsigned LeavesDef     = 1024;
  localparam int unsigned WeightBitsDef = 32;

  // Fixed port widths
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned FracW    = 32;
  localparam int unsigned BaseW    = 32;
  localparam int unsigned InWeightW = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_BUILD  = 2'd2,
    CMD_DRAW   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COMPLEMENT_ENABLE = 1'b0,
    CFG_COMPLEMENT_BASE   = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_BL_RD,
    ST_BL_WR,
    ST_BI_RL,
    ST_BI_RR,
    ST_BI_WR,
    ST_DR_ROOT,
    ST_DR_CHK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_ADD,
    ST_DS_RD,
    ST_DS_CMP,
    ST_AS_LEAF,
    ST_AS_UP
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/sum_tree_weighted_sampler.sv =====
// ============================================================================
// sum_tree_weighted_sampler
// Weighted sampling without replacement over a heap-ordered binary sum tree.
// ============================================================================
// Usage: software issues transactions on the input channel (valid/ready):
// clear, append one leaf weight, build the tree, or draw one leaf. Every
// transaction returns exactly one result (status, sample index) on the
// output channel (valid/ready). The block takes one transaction at a time;
// in_ready_o is high only while the sequencer is idle, and a finished
// result waits in the output register so the next transaction can enter.
// Clear and append go straight to the response step; a draw on an unbuilt
// tree or a zero total returns early. Run time is set by the single tree
// memory port (one access a cycle) and the single shared 32x32 multiplier
// used twice to scale the random fraction by the total weight. Descent
// spends a read and a compare per level; the way back up writes each
// ancestor from a small path register file, one write a cycle. Build
// copies the leaves (read, write) and then sums each internal node (read,
// read, write).
// Reset empties the leaf store and marks the tree unbuilt; the memories are
// not cleared and need no clearing pass. If the receiver stalls, the result
// holds in the output register and the sequencer holds at its last step.
// Configuration writes are registered straight into the settings. They are
// to be made only while idle: the user is bound to this, and the block
// itself does not enforce it.
`default_nettype none

module sum_tree_weighted_sampler #(
  parameter int unsigned LEAVES      = stws_pkg::LeavesDef,
  parameter int unsigned WEIGHT_BITS = stws_pkg::WeightBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [stws_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [stws_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [stws_pkg::CmdW-1:0]      command_i,
  input  wire logic [stws_pkg::InWeightW-1:0] leaf_weight_i,
  input  wire logic [stws_pkg::FracW-1:0]     random_fraction_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [stws_pkg::StatusW-1:0]        status_o,
  output logic [$clog2(LEAVES)-1:0]           sample_index_o
);

  import stws_pkg::*;

  // Tree geometry: P padded leaves, root at 1, leaf i at P+i
  localparam int unsigned Log2P     = $clog2(LEAVES);
  localparam int unsigned PadLeaves = 2 ** Log2P;
  localparam int unsigned AddrW     = Log2P + 1;
  localparam int unsigned TreeDepth = 2 ** AddrW;
  localparam int unsigned LvlW      = $clog2(Log2P + 1);
  localparam int unsigned PathDepth = 2 ** LvlW;
  localparam int unsigned CntW      = $clog2(LEAVES + 1);
  localparam int unsigned EffW      = (WEIGHT_BITS > BaseW) ? WEIGHT_BITS : BaseW;
  localparam int unsigned SumW      = EffW + Log2P;
  localparam int unsigned ProdW     = 2 * FracW;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e                  state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic                    built_q, built_d;
  logic                    cmp_en_q;
  logic [BaseW-1:0]        base_q;
  logic                    out_valid_q, out_valid_d;

  // payload / datapath registers, no reset needed
  logic [FracW-1:0]        rand_q, rand_d;
  logic [AddrW-1:0]        node_q, node_d;
  logic [LvlW-1:0]         lvl_q, lvl_d;
  logic [SumW-1:0]         cur_q, cur_d;      // sum of the node on the path
  logic [SumW-1:0]         u_q, u_d;          // scaled random target
  logic [SumW-1:0]         left_q, left_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  status_e                 status_q, status_d;
  logic [Log2P-1:0]        idx_q, idx_d;
  status_e                 out_status_q, out_status_d;
  logic [Log2P-1:0]        out_index_q, out_index_d;

  // path sums recorded on the way down, replayed on the way up
  logic [SumW-1:0]         path_q [PathDepth];
  logic                    path_we;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic [WEIGHT_BITS-1:0]  leaf_mem [LEAVES];
  logic                    leaf_we, leaf_re;
  logic [Log2P-1:0]        leaf_addr;
  logic [WEIGHT_BITS-1:0]  leaf_rdata_q;

  logic [SumW-1:0]         tree_mem [TreeDepth];
  logic                    tree_we, tree_re;
  logic [AddrW-1:0]        tree_addr;
  logic [SumW-1:0]         tree_wdata;
  logic [SumW-1:0]         tree_rdata_q;

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[leaf_addr] <= WEIGHT_BITS'(leaf_weight_i);
    end
    if (leaf_re) begin
      leaf_rdata_q <= leaf_mem[leaf_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      tree_mem[tree_addr] <= tree_wdata;
    end
    if (tree_re) begin
      tree_rdata_q <= tree_mem[tree_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Shared arithmetic
  // --------------------------------------------------------------------------
  logic [FracW-1:0] mul_a;
  logic [ProdW-1:0] prod;
  logic [EffW-1:0]  eff_raw, eff_base, eff_weight;
  logic [LvlW-1:0]  lvl_dec;
  logic             in_fire, out_free, leaf_live;

  // one 32x32 multiplier: low half of the total first, then the high half
  assign prod = ProdW'(mul_a) * ProdW'(rand_q);

  // effective weight, optionally complemented against the base and clamped
  assign eff_raw  = EffW'(leaf_rdata_q);
  assign eff_base = EffW'(base_q);
  always_comb begin
    eff_weight = eff_raw;
    if (cmp_en_q) begin
      eff_weight = (eff_base > eff_raw) ? (eff_base - eff_raw) : '0;
    end
  end

  assign lvl_dec   = lvl_q - LvlW'(1);
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign leaf_live = node_q < AddrW'(count_q);

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign sample_index_o = out_index_q;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    built_d      = built_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    rand_d       = rand_q;
    node_d       = node_q;
    lvl_d        = lvl_q;
    cur_d        = cur_q;
    u_d          = u_q;
    left_d       = left_q;
    prod_d       = prod_q;
    status_d     = status_q;
    idx_d        = idx_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;

    path_we    = 1'b0;
    leaf_we    = 1'b0;
    leaf_re    = 1'b0;
    leaf_addr  = node_q[Log2P-1:0];
    tree_we    = 1'b0;
    tree_re    = 1'b0;
    tree_addr  = node_q;
    tree_wdata = '0;
    mul_a      = cur_q[FracW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rand_d   = random_fraction_i;
          status_d = STS_OK;
          idx_d    = '0;
          case (cmd_e'(command_i))
            CMD_CLEAR: begin
              count_d = '0;
              built_d = 1'b0;
              state_d = ST_RESP;
            end
            CMD_APPEND: begin
              if (count_q >= CntW'(LEAVES)) begin
                status_d = STS_FULL;
              end else begin
                leaf_we   = 1'b1;
                leaf_addr = count_q[Log2P-1:0];
                count_d   = count_q + CntW'(1);
                built_d   = 1'b0;
              end
              state_d = ST_RESP;
            end
            CMD_BUILD: begin
              node_d  = '0;
              state_d = ST_BL_RD;
            end
            CMD_DRAW: begin
              if (built_q) begin
                state_d = ST_DR_ROOT;
              end else begin
                status_d = STS_EMPTY;
                state_d  = ST_RESP;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_RESP: begin
        // hold the result until the output register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_index_d  = idx_q;
          state_d      = ST_IDLE;
        end
      end

      // build: copy leaf j into tree slot P+j, padding slots get zero
      ST_BL_RD: begin
        leaf_re = leaf_live;
        state_d = ST_BL_WR;
      end

      ST_BL_WR: begin
        tree_we    = 1'b1;
        tree_addr  = {1'b1, node_q[Log2P-1:0]};
        tree_wdata = leaf_live ? SumW'(eff_weight) : '0;
        if (node_q == AddrW'(PadLeaves - 1)) begin
          // node stays at P-1: the first internal node to sum
          state_d = ST_BI_RL;
        end else begin
          node_d  = node_q + AddrW'(1);
          state_d = ST_BL_RD;
        end
      end

      // build: internal nodes from P-1 down to the root
      ST_BI_RL: begin
        tree_re   = 1'b1;
        tree_addr = {node_q[Log2P-1:0], 1'b0};
        state_d   = ST_BI_RR;
      end

      ST_BI_RR: begin
        tree_re   = 1'b1;
        tree_addr = {node_q[Log2P-1:0], 1'b1};
        left_d    = tree_rdata_q;
        state_d   = ST_BI_WR;
      end

      ST_BI_WR: begin
        tree_we    = 1'b1;
        tree_wdata = left_q + tree_rdata_q;
        if (node_q == AddrW'(1)) begin
          built_d = 1'b1;
          state_d = ST_RESP;
        end else begin
          node_d  = node_q - AddrW'(1);
          state_d = ST_BI_RL;
        end
      end

      // draw: fetch the total
      ST_DR_ROOT: begin
        tree_re   = 1'b1;
        tree_addr = AddrW'(1);
        state_d   = ST_DR_CHK;
      end

      ST_DR_CHK: begin
        cur_d = tree_rdata_q;
        if (tree_rdata_q == '0) begin
          status_d = STS_EMPTY;
          state_d  = ST_RESP;
        end else begin
          state_d = ST_MUL_LO;
        end
      end

      // u = hi*r + ((lo*r) >> 32)
      ST_MUL_LO: begin
        mul_a   = cur_q[FracW-1:0];
        prod_d  = prod;
        state_d = ST_MUL_HI;
      end

      ST_MUL_HI: begin
        mul_a   = FracW'(cur_q >> FracW);
        prod_d  = prod;
        u_d     = SumW'(prod_q[ProdW-1:FracW]);
        state_d = ST_MUL_ADD;
      end

      ST_MUL_ADD: begin
        u_d     = u_q + SumW'(prod_q);
        node_d  = AddrW'(1);
        lvl_d   = '0;
        state_d = ST_DS_RD;
      end

      // descent: read the left child, then steer
      ST_DS_RD: begin
        tree_re   = 1'b1;
        tree_addr = {node_q[Log2P-1:0], 1'b0};
        path_we   = 1'b1;
        state_d   = ST_DS_CMP;
      end

      ST_DS_CMP: begin
        if (u_q < tree_rdata_q) begin
          node_d = {node_q[Log2P-1:0], 1'b0};
          cur_d  = tree_rdata_q;
        end else begin
          node_d = {node_q[Log2P-1:0], 1'b1};
          u_d    = u_q - tree_rdata_q;
          cur_d  = cur_q - tree_rdata_q;
        end
        lvl_d = lvl_q + LvlW'(1);
        if (lvl_q == LvlW'(Log2P - 1)) begin
          state_d = ST_AS_LEAF;
        end else begin
          state_d = ST_DS_RD;
        end
      end

      // drop the chosen leaf; cur_q now holds its weight
      ST_AS_LEAF: begin
        tree_we    = 1'b1;
        tree_wdata = '0;
        idx_d      = node_q[Log2P-1:0];
        state_d    = ST_AS_UP;
      end

      // every ancestor loses exactly the leaf weight
      ST_AS_UP: begin
        tree_we    = 1'b1;
        tree_addr  = node_q >> 1;
        tree_wdata = path_q[lvl_dec] - cur_q;
        node_d     = node_q >> 1;
        lvl_d      = lvl_dec;
        if (lvl_q == LvlW'(1)) begin
          status_d = STS_OK;
          state_d  = ST_RESP;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cmp_en_q    <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      built_q     <= built_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_COMPLEMENT_ENABLE: cmp_en_q <= cfg_wdata_i[0];
          CFG_COMPLEMENT_BASE:   base_q   <= BaseW'(cfg_wdata_i);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rand_q       <= rand_d;
    node_q       <= node_d;
    lvl_q        <= lvl_d;
    cur_q        <= cur_d;
    u_q          <= u_d;
    left_q       <= left_d;
    prod_q       <= prod_d;
    status_q     <= status_d;
    idx_q        <= idx_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    if (path_we) begin
      path_q[lvl_q] <= cur_q;
    end
  end

endmodule

`default_nettype wire

// ===== verif/sum_tree_weighted_sampler_checker.sv =====
// ============================================================================
// sum_tree_weighted_sampler_checker
// Watches the sampler's channels, predicts each result and compares it.
// ----------------------------------------------------------------------------
// Keeps its own leaf store, sum tree and complement settings. Every accepted
// command queues one predicted (status, index) pair; every accepted result is
// checked against the oldest one. The failure count and the number of
// results still due go back to the testbench top.
// ============================================================================
module sum_tree_weighted_sampler_checker
  import stws_pkg::*;
#(
  parameter int unsigned LEAVES      = LeavesDef,
  parameter int unsigned WEIGHT_BITS = WeightBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [CmdW-1:0]           command_i,
  input  logic [InWeightW-1:0]      leaf_weight_i,
  input  logic [FracW-1:0]          random_fraction_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [StatusW-1:0]        status_i,
  input  logic [$clog2(LEAVES)-1:0] sample_index_i,
  output int unsigned               mismatch_count_o,
  output int unsigned               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdxW      = $clog2(LEAVES);
  localparam int unsigned PadLeaves = 1 << IdxW;
  localparam logic [63:0] WeightMask = (64'd1 << WEIGHT_BITS) - 64'd1;
  localparam int unsigned PrintCap  = 40;

  typedef struct packed {
    status_e         status;
    logic [IdxW-1:0] index;
  } draw_outcome_t;

  logic [63:0]   stored_weight [LEAVES];
  logic [63:0]   node_sum [2*PadLeaves];
  int unsigned   stored_count;
  bit            tree_valid;
  bit            cmpl_enable;
  logic [BaseW-1:0] cmpl_base;

  draw_outcome_t awaited_q [$];
  int unsigned   mismatches = 0;
  int unsigned   results_seen = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string what);
    if (mismatches < PrintCap) begin
      $display("%0t ns: result %0d: %s", $time, results_seen, what);
    end
    mismatches++;
  endtask

  function automatic logic [63:0] effective_weight(input logic [63:0] w);
    if (cmpl_enable) begin
      return (64'(cmpl_base) > w) ? 64'(cmpl_base) - w : 64'd0;
    end
    return w;
  endfunction

  function automatic void rebuild_sums();
    for (int unsigned i = 0; i < PadLeaves; i++) begin
      node_sum[PadLeaves + i] = 64'd0;
      if (i < stored_count && i < LEAVES) begin
        node_sum[PadLeaves + i] = effective_weight(stored_weight[i]);
      end
    end
    for (int unsigned i = PadLeaves - 1; i >= 1; i--) begin
      node_sum[i] = node_sum[2*i] + node_sum[2*i + 1];
    end
    tree_valid = 1'b1;
  endfunction

  // Apply one command to the shadow state and return what the block owes.
  function automatic draw_outcome_t next_outcome(input cmd_e cmd, input logic [31:0] weight,
                                                 input logic [31:0] frac);
    draw_outcome_t res;
    logic [63:0]   total;
    logic [63:0]   u;
    int unsigned   node;
    res.status = STS_OK;
    res.index  = '0;
    case (cmd)
      CMD_CLEAR: begin
        stored_count = 0;
        tree_valid   = 1'b0;
      end
      CMD_APPEND: begin
        if (stored_count >= LEAVES) begin
          res.status = STS_FULL;
        end else begin
          stored_weight[stored_count] = 64'(weight) & WeightMask;
          stored_count++;
          tree_valid = 1'b0;
        end
      end
      CMD_BUILD: rebuild_sums();
      default: begin
        total = node_sum[1];
        if (!tree_valid || total == 64'd0) begin
          res.status = STS_EMPTY;
        end else begin
          // scale the fraction by the total, keeping the product exact
          u = (total >> 32) * 64'(frac) + (((total & 64'hFFFF_FFFF) * 64'(frac)) >> 32);
          node = 1;
          while (node < PadLeaves) begin
            if (u < node_sum[2*node]) begin
              node = 2*node;
            end else begin
              u    = u - node_sum[2*node];
              node = 2*node + 1;
            end
          end
          res.index = IdxW'(node - PadLeaves);
          // drop the drawn leaf and refresh its ancestors
          node_sum[node] = 64'd0;
          while (node > 1) begin
            node = node >> 1;
            node_sum[node] = node_sum[2*node] + node_sum[2*node + 1];
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    draw_outcome_t want;
    draw_outcome_t fresh;
    int unsigned   pushed;
    int unsigned   popped;
    if (!rst_ni) begin
      stored_count = 0;
      tree_valid   = 1'b0;
      cmpl_enable  = 1'b0;
      cmpl_base    = '0;
      awaited_q.delete();
      outstanding_o <= 0;
    end else begin
      pushed = 0;
      popped = 0;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_COMPLEMENT_ENABLE: cmpl_enable = cfg_wdata_i[0];
          CFG_COMPLEMENT_BASE:   cmpl_base   = cfg_wdata_i[BaseW-1:0];
          default: ;
        endcase
      end
      // check the result first so a stray one never takes a fresh prediction
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result, status %0d index %0d",
                                    status_i, sample_index_i));
        end else begin
          want   = awaited_q.pop_front();
          popped = 1;
          if (status_i !== want.status) begin
            report_mismatch($sformatf("status %0d, predicted %0d", status_i, want.status));
          end
          if (sample_index_i !== want.index) begin
            report_mismatch($sformatf("index %0d, predicted %0d", sample_index_i, want.index));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        fresh = next_outcome(cmd_e'(command_i), leaf_weight_i, random_fraction_i);
        awaited_q.insert(awaited_q.size(), fresh);
        pushed = 1;
      end
      outstanding_o <= outstanding_o + pushed - popped;
    end
  end

endmodule

// ===== verif/tb_sum_tree_weighted_sampler.sv =====
// ============================================================================
// tb_sum_tree_weighted_sampler
// Stimulus and verdict for the sum tree weighted sampler.
// ----------------------------------------------------------------------------
// Runs a short directed sequence (empty tree, unbuilt tree, extreme weights
// and fractions, exhaustion, complement clamping), one pass that fills the
// leaf store past its capacity, and then random load/build/draw sets over
// several complement settings. Both channels idle at random; the checker
// beside the block predicts and compares every result.
// ============================================================================
module tb_sum_tree_weighted_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  import stws_pkg::*;

  localparam int unsigned Leaves      = LeavesDef;
  localparam int unsigned IdxW        = $clog2(Leaves);
  localparam int unsigned RandomItems = 600;
  localparam int unsigned PhaseItems  = 100;
  // a build walks the whole tree; leave wide margin
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned TailCycles  = 64;

  // how appended weights are drawn for one load/build/draw set
  typedef enum int unsigned {
    WS_FULL,
    WS_TINY,
    WS_NEAR_BASE,
    WS_EXTREME,
    WS_SPREAD
  } weight_style_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [CmdW-1:0]       command_i = '0;
  logic [InWeightW-1:0]  leaf_weight_i = '0;
  logic [FracW-1:0]      random_fraction_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [StatusW-1:0]    status_o;
  logic [IdxW-1:0]       sample_index_o;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 63;

  sum_tree_weighted_sampler dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .leaf_weight_i     (leaf_weight_i),
    .random_fraction_i (random_fraction_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .sample_index_o    (sample_index_o)
  );

  sum_tree_weighted_sampler_checker outcome_monitor (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .command_i         (command_i),
    .leaf_weight_i     (leaf_weight_i),
    .random_fraction_i (random_fraction_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_i          (status_o),
    .sample_index_i    (sample_index_o),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: drop ready at random according to the current idle rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one transaction and hold it until the block takes it. Valid stays
  // high on return so a back-to-back transaction needs no extra edge.
  task automatic send_item(input cmd_e cmd, input logic [31:0] weight,
                           input logic [31:0] frac);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i        <= 1'b1;
    command_i         <= cmd;
    leaf_weight_i     <= weight;
    random_fraction_i <= frac;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Hold off the sender until every result owed has come back. The first
  // edge lets the count pick up a transaction accepted at this very edge.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Write both complement registers; call only while the block is idle.
  task automatic set_complement(input bit enable, input logic [31:0] base);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_COMPLEMENT_ENABLE;
    cfg_wdata_i <= {31'd0, enable};
    @(posedge clk_i);
    cfg_index_i <= CFG_COMPLEMENT_BASE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_weight(input weight_style_e style,
                                              input logic [31:0] base);
    case (style)
      WS_FULL:      return $urandom();
      WS_TINY:      return $urandom_range(31);
      // land close to the complement base so clamping shows up
      WS_NEAR_BASE: return base + 32'($urandom_range(8)) - 32'd4;
      WS_EXTREME: begin
        case ($urandom_range(3))
          0:       return 32'd0;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'd1;
          default: return 32'h8000_0000;
        endcase
      end
      default:      return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  function automatic logic [31:0] pick_fraction();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // One load/build/draw set with random content, plus a little noise:
  // stray commands among the appends, draws before the build, rebuilds
  // in the middle of the draws and appends that invalidate the tree.
  task automatic run_set(input logic [31:0] base);
    weight_style_e style;
    int unsigned   leaves;
    int unsigned   draws;
    int unsigned   roll;
    style = weight_style_e'($urandom_range(4));
    roll  = $urandom_range(99);
    if (roll < 5) begin
      leaves = $urandom_range(120, 41);
    end else if (roll < 20) begin
      leaves = $urandom_range(40, 13);
    end else begin
      leaves = $urandom_range(12, 1);
    end
    // mostly run the tree dry and then some; sometimes stop early
    if ($urandom_range(99) < 30) begin
      draws = $urandom_range(leaves, 1);
    end else begin
      draws = leaves + $urandom_range(2);
    end
    if ($urandom_range(99) < 80) send_item(CMD_CLEAR, $urandom(), $urandom());
    if ($urandom_range(99) < 10) send_item(CMD_DRAW, $urandom(), pick_fraction());
    for (int unsigned i = 0; i < leaves; i++) begin
      if ($urandom_range(99) < 4) send_item(cmd_e'($urandom_range(3)), $urandom(), $urandom());
      send_item(CMD_APPEND, pick_weight(style, base), $urandom());
    end
    send_item(CMD_BUILD, $urandom(), $urandom());
    for (int unsigned i = 0; i < draws; i++) begin
      if ($urandom_range(99) < 2) send_item(CMD_BUILD, $urandom(), $urandom());
      send_item(CMD_DRAW, $urandom(), pick_fraction());
    end
    if ($urandom_range(99) < 10) begin
      send_item(CMD_APPEND, pick_weight(style, base), $urandom());
      send_item(CMD_DRAW, $urandom(), pick_fraction());
    end
  endtask

  initial begin : stimulus
    int unsigned random_start;
    int unsigned phase_end;
    int unsigned done;
    int unsigned phase;
    bit          cmpl_on;
    logic [31:0] cmpl_base;

    // Hold reset, release it, and let the block sit idle before the first item.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: complement off, base zero (reset values) ---
    send_item(CMD_DRAW, 32'hFFFF_FFFF, 32'h1234_5678);   // tree never built
    send_item(CMD_BUILD, 32'd0, 32'd0);                  // build with no leaves
    send_item(CMD_DRAW, 32'd0, 32'hFFFF_FFFF);           // empty tree
    send_item(CMD_APPEND, 32'd0, 32'd0);
    send_item(CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_APPEND, 32'd1, 32'd0);
    send_item(CMD_APPEND, 32'h8000_0000, 32'd0);
    send_item(CMD_DRAW, 32'd0, 32'h8000_0000);           // append dropped the tree
    send_item(CMD_BUILD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_DRAW, 32'd0, 32'd0);                   // lowest fraction
    send_item(CMD_DRAW, 32'd0, 32'hFFFF_FFFF);           // highest fraction
    send_item(CMD_DRAW, 32'd0, 32'h8000_0000);
    send_item(CMD_DRAW, 32'd0, 32'h4000_0000);           // total now zero
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_DRAW, 32'd0, 32'd0);                   // cleared, not built
    send_item(CMD_APPEND, 32'd0, 32'd0);
    send_item(CMD_APPEND, 32'd0, 32'd0);
    send_item(CMD_BUILD, 32'd0, 32'd0);
    send_item(CMD_DRAW, 32'd0, 32'h7FFF_FFFF);           // all weights zero

    // Complement on: small base, one weight at the base, one far above it.
    drain_results();
    set_complement(1'b1, 32'h10);
    send_item(CMD_CLEAR, 32'd0, 32'd0);
    send_item(CMD_APPEND, 32'd5, 32'd0);
    send_item(CMD_APPEND, 32'h10, 32'd0);                // clamps to zero
    send_item(CMD_APPEND, 32'hFFFF_FFFF, 32'd0);         // clamps to zero
    send_item(CMD_BUILD, 32'd0, 32'd0);
    send_item(CMD_DRAW, 32'd0, 32'hFFFF_FFFF);
    send_item(CMD_DRAW, 32'd0, 32'd0);                   // exhausted

    // Fill the store to capacity and push two more appends past it.
    send_item(CMD_CLEAR, $urandom(), $urandom());
    for (int unsigned i = 0; i < Leaves + 2; i++) begin
      send_item(CMD_APPEND, pick_weight(WS_TINY, 32'h10), $urandom());
    end
    send_item(CMD_BUILD, $urandom(), $urandom());
    repeat (6) send_item(CMD_DRAW, $urandom(), pick_fraction());

    // --- random sets, one complement setting per phase ---
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RandomItems) begin
      // config only changes once every result is back
      drain_results();
      case (phase)
        0: begin cmpl_on = 1'b0; cmpl_base = $urandom();          end
        1: begin cmpl_on = 1'b1; cmpl_base = 32'd0;               end
        2: begin cmpl_on = 1'b1; cmpl_base = 32'hFFFF_FFFF;       end
        3: begin cmpl_on = 1'b1; cmpl_base = $urandom_range(64);  end
        4: begin cmpl_on = 1'b1; cmpl_base = $urandom();          end
        5: begin cmpl_on = 1'b0; cmpl_base = 32'hFFFF_FFFF;       end
        default: begin
          cmpl_on   = $urandom_range(1);
          cmpl_base = ($urandom_range(3) == 0) ? 32'($urandom_range(64)) : $urandom();
        end
      endcase
      set_complement(cmpl_on, cmpl_base);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end && items_sent - random_start < RandomItems) begin
        // swap the idle rates after a third, stop idling after two thirds
        done = items_sent - random_start;
        if (done >= 2 * RandomItems / 3) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end else if (done >= RandomItems / 3) begin
          send_idle_pct = 63;
          recv_idle_pct = 31;
        end
        run_set(cmpl_base);
      end
      phase++;
    end

    // Let the last results in, then watch a while for anything stray.
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
